/* sv/ctbm_pkg.sv */
// Shared constants, types and arithmetic helpers of the block tridiagonal matvec.
package ctbm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH - FRAC_BITS;
    localparam int WIDE_W     = 2 * DATA_WIDTH + 2;

    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [WIDE_W-1:0]     t_wide;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TAU1  = 3'd0,
        REG_TAU2  = 3'd1,
        REG_ALPHA = 3'd2,
        REG_BETA  = 3'd3,
        REG_SIGMA = 3'd4
    } t_reg_idx;

    localparam t_data TAU1_RST  = t_data'(0);
    localparam t_data TAU2_RST  = t_data'(0);
    localparam t_data ALPHA_RST = t_data'(131072);
    localparam t_data BETA_RST  = t_data'(357171);
    localparam t_data SIGMA_RST = t_data'(0);

    localparam t_wide ONE_W  = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide MAX_W  = t_wide'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam t_wide MIN_W  = -MAX_W - t_wide'(1);

    typedef struct packed {
        logic  vld;
        logic  last;
        t_data lap1;
        t_data lap2;
        t_data x1;
        t_data x2;
    } t_job;

    typedef struct packed {
        logic  vld;
        logic  last;
        t_data lap;
        t_data x1;
        t_data x2;
    } t_lane_op;

    typedef struct packed {
        t_data tau;
        t_data k1;
        t_data k2;
    } t_coef;

    typedef struct packed {
        logic  vld;
        logic  last;
        t_data y;
    } t_lane_res;

    typedef struct packed {
        t_data y1;
        t_data y2;
        logic  last;
    } t_row;

    function automatic t_data sat_dw(input t_wide v);
        t_data r;
        if (v > MAX_W) begin
            r = MAX_W[DATA_WIDTH-1:0];
        end else if (v < MIN_W) begin
            r = MIN_W[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // floor(a*b / 2^F)
    function automatic t_prod mul_trunc(input t_data a, input t_data b);
        logic signed [2*DATA_WIDTH-1:0] p;
        p = a * b;
        return t_prod'(p >>> FRAC_BITS);
    endfunction

    function automatic t_data lap_of(input t_data l, input t_data c, input t_data r);
        return sat_dw(t_wide'(l) - (t_wide'(c) <<< 1) + t_wide'(r));
    endfunction

    function automatic t_data sq_of(input t_data a);
        return sat_dw(t_wide'(mul_trunc(a, a)));
    endfunction

endpackage

/* sv/ctbm_in_if.sv */
// Input stream channel: one index pair per transfer.
interface ctbm_in_if;
    import ctbm_pkg::*;

    logic  valid;
    logic  ready;
    t_data first_in;
    t_data second_in;
    logic  final_index;

    modport source (output valid, output first_in, output second_in, output final_index,
                    input ready);
    modport sink   (input valid, input first_in, input second_in, input final_index,
                    output ready);
endinterface

/* sv/ctbm_out_if.sv */
// Output stream channel: one result row per transfer.
interface ctbm_out_if;
    import ctbm_pkg::*;

    logic  valid;
    logic  ready;
    t_data first_out;
    t_data second_out;
    logic  row_last;

    modport source (output valid, output first_out, output second_out, output row_last,
                    input ready);
    modport sink   (input valid, input first_out, input second_out, input row_last,
                    output ready);
endinterface

/* sv/ctbm_lane.sv */
// One row lane: y = tau*lap + k1*x1 + k2*x2, truncated products, saturated sum.
module ctbm_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctbm_pkg::t_lane_op i_op,
    input  ctbm_pkg::t_coef    i_coef,
    output ctbm_pkg::t_lane_res o_res
);
    import ctbm_pkg::*;

    logic  r_m_vld;
    logic  r_m_last;
    t_prod r_p0;
    t_prod r_p1;
    t_prod r_p2;
    t_wide w_sum;
    t_lane_res r_res;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= i_op.vld;
        end
        r_m_last <= i_op.last;
        r_p0     <= mul_trunc(i_coef.tau, i_op.lap);
        r_p1     <= mul_trunc(i_coef.k1, i_op.x1);
        r_p2     <= mul_trunc(i_coef.k2, i_op.x2);
    end

    assign w_sum = t_wide'(r_p0) + t_wide'(r_p1) + t_wide'(r_p2);

    // sum and saturate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld <= r_m_vld;
        end
        r_res.last <= r_m_last;
        r_res.y    <= sat_dw(w_sum);
    end

    assign o_res = r_res;

endmodule

/* sv/ctbm_merge.sv */
// Merges the two lane results into rows and queues them for the output channel.
module ctbm_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctbm_pkg::t_lane_res i_res_a,
    input  ctbm_pkg::t_lane_res i_res_b,
    ctbm_out_if.source          o_out
);
    import ctbm_pkg::*;

    t_row             r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_push;
    logic             w_pop;
    t_row             w_row;

    assign w_push = i_res_a.vld & i_res_b.vld;
    assign w_pop  = o_out.valid & o_out.ready;

    always_comb begin
        w_row.y1   = i_res_a.y;
        w_row.y2   = i_res_b.y;
        w_row.last = i_res_a.last & i_res_b.last;
        n_cnt      = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wr] <= w_row;
        end
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.first_out  = r_mem[r_rd].y1;
    assign o_out.second_out = r_mem[r_rd].y2;
    assign o_out.row_last   = r_mem[r_rd].last;

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_a.vld == i_res_b.vld)
        else $error("lanes out of step");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt < CNT_W'(OUT_DEPTH)) || w_pop)
        else $error("row queue overflow");

    a_cnt_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("row queue count lost a push");

endmodule

/* sv/coupled_tridiagonal_block_matvec.sv */
// Top level: config registers, index history, row sequencing, two lanes and merge.
// Each row is registered in r_job, the lane multiply and sum stages and the merge queue.
// Flow: input is taken only while no row is pending and at most two rows are in flight
// (issued, not yet taken from o_out); the pair flagged final_index produces two rows
// (one if no pair came before it) and holds the input while its second row is pending.
// Reset (synchronous, active low) restores the register defaults and starts a new vector.
module coupled_tridiagonal_block_matvec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ctbm_in_if.sink                       i_in,
    ctbm_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctbm_pkg::ADDR_W-1:0]   paddr,
    input  logic [ctbm_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [ctbm_pkg::DATA_WIDTH-1:0] prdata,
    output logic                          pready
);
    import ctbm_pkg::*;

    t_data r_tau1;
    t_data r_tau2;
    t_data r_alpha;
    t_data r_beta;
    t_data r_sigma;
    t_data r_a2;
    t_data r_c11;
    t_data r_c22;
    t_data r_nb;

    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    logic  r_started;
    t_data r_h1_prev;
    t_data r_h1_cur;
    t_data r_h2_prev;
    t_data r_h2_cur;

    t_job r_job;
    t_job n_job;
    t_job r_pend;
    t_job n_pend;
    t_job w_job0;
    t_job w_job1;

    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic [CNT_W-1:0] w_rows;
    logic             w_accept;
    logic             w_pop;
    t_data            w_left1;
    t_data            w_left2;

    t_lane_op  w_op_a;
    t_lane_op  w_op_b;
    t_coef     w_coef_a;
    t_coef     w_coef_b;
    t_lane_res w_res_a;
    t_lane_res w_res_b;

    // configuration
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau1  <= TAU1_RST;
            r_tau2  <= TAU2_RST;
            r_alpha <= ALPHA_RST;
            r_beta  <= BETA_RST;
            r_sigma <= SIGMA_RST;
            r_a2    <= sq_of(ALPHA_RST);
        end else if (w_wr) begin
            case (t_reg_idx'(w_idx))
                REG_TAU1:  r_tau1  <= pwdata;
                REG_TAU2:  r_tau2  <= pwdata;
                REG_ALPHA: begin
                    r_alpha <= pwdata;
                    r_a2    <= sq_of(pwdata);
                end
                REG_BETA:  r_beta  <= pwdata;
                REG_SIGMA: r_sigma <= pwdata;
                default: ;
            endcase
        end
    end

    // derived coefficients, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        r_c11 <= sat_dw(t_wide'(r_beta) - ONE_W + t_wide'(r_sigma));
        r_c22 <= sat_dw(t_wide'(r_sigma) - t_wide'(r_a2));
        r_nb  <= sat_dw(-t_wide'(r_beta));
    end

    always_comb begin
        case (t_reg_idx'(w_idx))
            REG_TAU1:  prdata = r_tau1;
            REG_TAU2:  prdata = r_tau2;
            REG_ALPHA: prdata = r_alpha;
            REG_BETA:  prdata = r_beta;
            REG_SIGMA: prdata = r_sigma;
            default:   prdata = '0;
        endcase
    end

    // row sequencing
    assign w_accept  = i_in.valid & i_in.ready;
    assign w_pop     = o_out.valid & o_out.ready;
    assign i_in.ready = !r_pend.vld && (r_used <= CNT_W'(OUT_DEPTH - 2));

    always_comb begin
        w_left1 = r_started ? r_h1_cur : '0;
        w_left2 = r_started ? r_h2_cur : '0;

        w_job0.vld  = r_started;
        w_job0.last = 1'b0;
        w_job0.lap1 = lap_of(r_h1_prev, r_h1_cur, i_in.first_in);
        w_job0.lap2 = lap_of(r_h2_prev, r_h2_cur, i_in.second_in);
        w_job0.x1   = r_h1_cur;
        w_job0.x2   = r_h2_cur;

        w_job1.vld  = i_in.final_index;
        w_job1.last = 1'b1;
        w_job1.lap1 = lap_of(w_left1, i_in.first_in, '0);
        w_job1.lap2 = lap_of(w_left2, i_in.second_in, '0);
        w_job1.x1   = i_in.first_in;
        w_job1.x2   = i_in.second_in;

        w_rows = CNT_W'(w_job0.vld) + CNT_W'(w_job1.vld);

        if (w_accept) begin
            n_job      = w_job0.vld ? w_job0 : w_job1;
            n_pend     = w_job1;
            n_pend.vld = w_job0.vld & w_job1.vld;
        end else begin
            n_job      = r_pend;
            n_pend     = r_pend;
            n_pend.vld = 1'b0;
        end

        n_used = r_used + (w_accept ? w_rows : '0) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_job.vld <= 1'b0;
            r_pend.vld <= 1'b0;
            r_used    <= '0;
        end else begin
            if (w_accept) begin
                r_started <= !i_in.final_index;
            end
            r_job.vld  <= n_job.vld;
            r_pend.vld <= n_pend.vld;
            r_used     <= n_used;
        end
        r_job.last  <= n_job.last;
        r_job.lap1  <= n_job.lap1;
        r_job.lap2  <= n_job.lap2;
        r_job.x1    <= n_job.x1;
        r_job.x2    <= n_job.x2;
        r_pend.last <= n_pend.last;
        r_pend.lap1 <= n_pend.lap1;
        r_pend.lap2 <= n_pend.lap2;
        r_pend.x1   <= n_pend.x1;
        r_pend.x2   <= n_pend.x2;
        if (w_accept) begin
            r_h1_prev <= w_left1;
            r_h2_prev <= w_left2;
            r_h1_cur  <= i_in.first_in;
            r_h2_cur  <= i_in.second_in;
        end
    end

    // lanes
    always_comb begin
        w_op_a.vld  = r_job.vld;
        w_op_a.last = r_job.last;
        w_op_a.lap  = r_job.lap1;
        w_op_a.x1   = r_job.x1;
        w_op_a.x2   = r_job.x2;
        w_op_b      = w_op_a;
        w_op_b.lap  = r_job.lap2;

        w_coef_a.tau = r_tau1;
        w_coef_a.k1  = r_c11;
        w_coef_a.k2  = r_a2;
        w_coef_b.tau = r_tau2;
        w_coef_b.k1  = r_nb;
        w_coef_b.k2  = r_c22;
    end

    ctbm_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op_a),
        .i_coef  (w_coef_a),
        .o_res   (w_res_a)
    );

    ctbm_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op_b),
        .i_coef  (w_coef_b),
        .o_res   (w_res_b)
    );

    ctbm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res_a (w_res_a),
        .i_res_b (w_res_b),
        .o_out   (o_out)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(OUT_DEPTH))
        else $error("row credit count beyond queue depth");

    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend.vld |-> r_job.vld && !r_job.last && r_pend.last)
        else $error("pending row out of order");

    a_final_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.final_index |=> (r_pend.vld ? r_pend.last : r_job.last && r_job.vld))
        else $error("final transfer did not issue a last row");

    a_first_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !r_started && !i_in.final_index |=> !r_job.vld)
        else $error("first element issued a row");

endmodule
